/* hdl/dfr_pkg.sv */
// ----------------------------------------------------------------------------
// dfr_pkg - shared types and constants of the http/3 stream deframer
// per-slot context layout, parse phases, byte classes and queue types
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int VARINT_W   = 62;
  localparam int MAXHDR_W   = 24;
  localparam int SLOT_W     = 4;
  localparam int SLOT_COUNT = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [MAXHDR_W-1:0] MAXHDR_RESET  = 24'h10_0000;
  localparam logic [VARINT_W-1:0] TYPE_ENCODER  = 62'd2;
  localparam logic [VARINT_W-1:0] FRAME_HEADERS = 62'd1;

  // register index is paddr[2]
  localparam logic REG_MAX_HDR = 1'b0;

  typedef enum logic [7:0] {
    PH_START     = 8'b0000_0001,
    PH_STYPE     = 8'b0000_0010,
    PH_ENCODER   = 8'b0000_0100,
    PH_IGNORE    = 8'b0000_1000,
    PH_FTYPE     = 8'b0001_0000,
    PH_LEN_FIRST = 8'b0010_0000,
    PH_LEN_MORE  = 8'b0100_0000,
    PH_PAYLOAD   = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    CLS_DROP    = 3'd0,
    CLS_FRAMING = 3'd1,
    CLS_ENCODER = 3'd2,
    CLS_HEADER  = 3'd3,
    CLS_EMPTY   = 3'd4
  } cls_e;

  // classified input byte
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              uni;
    logic              restart;
    logic [7:0]        data;
    logic [2:0]        vleft;   // varint bytes left if this byte opens a varint
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_ctrl_t;

  // acc holds the varint being built or, in payload, the bytes still to come
  typedef struct packed {
    phase_e              phase;
    logic [VARINT_W-1:0] acc;
    logic [2:0]          left;
    logic                hdr;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{phase: PH_START, acc: '0, left: '0, hdr: 1'b0};

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    cls_e              cls;
    logic [7:0]        data;
    logic              last;
  } res_t;

endpackage

/* hdl/dfr_front.sv */
// ----------------------------------------------------------------------------
// dfr_front - input side of the deframer
// takes stream bytes, decodes the varint length prefix, queues them
// ----------------------------------------------------------------------------
module dfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic [5:0]        s_axis_tuser,   // [3:0] stream_slot, [4] unidirectional, [5] restart
  input  dfr_pkg::bk_ctrl_t bk_ctrl_i,
  output dfr_pkg::q_head_t  head_o
);
  import dfr_pkg::*;

  item_t             q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push;
  logic [3:0]        len_onehot;
  item_t             in_item;

  // varint length from the two top bits: 1, 2, 4 or 8 bytes
  assign len_onehot = 4'd1 << s_axis_tdata[7:6];

  always_comb begin
    in_item.slot    = s_axis_tuser[3:0];
    in_item.uni     = s_axis_tuser[4];
    in_item.restart = s_axis_tuser[5];
    in_item.data    = s_axis_tdata;
    in_item.vleft   = 3'(len_onehot - 4'd1);
  end

  assign s_axis_tready = (count_q != (QPTR_W+1)'(QDEPTH)) && !bk_ctrl_i.init_busy;
  assign push          = s_axis_tvalid && s_axis_tready;

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = bk_ctrl_i.pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !bk_ctrl_i.pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (!push && bk_ctrl_i.pop) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

/* hdl/dfr_back.sv */
// ----------------------------------------------------------------------------
// dfr_back - context memory, parse step and result register
// reads the slot context, advances the parser, writes the context back
// ----------------------------------------------------------------------------
module dfr_back #(
  parameter int STREAM_SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dfr_pkg::q_head_t                head_i,
  output dfr_pkg::bk_ctrl_t               ctrl_o,
  input  logic [dfr_pkg::MAXHDR_W-1:0]    max_hdr_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
  output logic [6:0]                      m_axis_tuser,   // [3:0] out_slot, [6:4] byte_class
  output logic                            m_axis_tlast    // section_last
);
  import dfr_pkg::*;

  localparam int IDX_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  ctx_t             ctx_mem [STREAM_SLOTS];
  logic [IDX_W-1:0] slot_map [SLOT_COUNT];

  logic             init_busy_q;
  logic [IDX_W-1:0] init_cnt_q;

  logic             e_valid_q;
  item_t            e_item_q;
  logic [IDX_W-1:0] e_idx_q;
  ctx_t             e_ctx_q;

  logic             out_valid_q;
  res_t             out_res_q;

  logic             e_fire, e_free, pop;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic             we;
  ctx_t             wr_ctx;

  ctx_t                cur, nxt;
  res_t                res;
  logic [VARINT_W-1:0] acc_m, low6v, len_sel;
  logic [2:0]          left_m;
  logic                done_m, len_fin, len_over, len_hdr, len_zero;

  // slot folding onto the configured context count, settled at elaboration
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot_map
    assign slot_map[g] = IDX_W'(g % STREAM_SLOTS);
  end

  assign e_fire = e_valid_q && (!out_valid_q || m_axis_tready);
  assign e_free = !e_valid_q || e_fire;
  assign pop    = head_i.valid && !init_busy_q && e_free;
  assign rd_idx = slot_map[head_i.item.slot];

  assign ctrl_o.pop       = pop;
  assign ctrl_o.init_busy = init_busy_q;

  assign we     = e_fire || init_busy_q;
  assign wr_idx = init_busy_q ? init_cnt_q : e_idx_q;
  assign wr_ctx = init_busy_q ? CTX_RESET : nxt;

  // parse step
  always_comb begin
    cur      = e_item_q.restart ? CTX_RESET : e_ctx_q;
    nxt      = cur;
    low6v    = {56'b0, e_item_q.data[5:0]};
    acc_m    = {cur.acc[VARINT_W-9:0], e_item_q.data};
    left_m   = (cur.left != 3'd0) ? cur.left - 3'd1 : cur.left;
    done_m   = (left_m == 3'd0);
    len_sel  = (cur.phase == PH_LEN_FIRST) ? low6v : acc_m;
    len_over = (|len_sel[VARINT_W-1:MAXHDR_W]) || (len_sel[MAXHDR_W-1:0] > max_hdr_i);
    len_hdr  = cur.hdr && !len_over;
    len_zero = (len_sel == '0);
    len_fin  = 1'b0;
    res.slot = e_item_q.slot;
    res.cls  = CLS_FRAMING;
    res.data = e_item_q.data;
    res.last = 1'b0;

    case (cur.phase)
      PH_START: begin
        nxt.acc  = low6v;
        nxt.left = e_item_q.vleft;
        if (e_item_q.vleft != 3'd0) begin
          nxt.phase = e_item_q.uni ? PH_STYPE : PH_FTYPE;
        end else if (e_item_q.uni) begin
          nxt.phase = (low6v == TYPE_ENCODER) ? PH_ENCODER : PH_IGNORE;
          nxt.acc   = '0;
        end else begin
          nxt.hdr   = (low6v == FRAME_HEADERS);
          nxt.acc   = '0;
          nxt.phase = PH_LEN_FIRST;
        end
      end
      PH_STYPE: begin
        nxt.acc  = acc_m;
        nxt.left = left_m;
        if (done_m) begin
          nxt.phase = (acc_m == TYPE_ENCODER) ? PH_ENCODER : PH_IGNORE;
          nxt.acc   = '0;
        end
      end
      PH_ENCODER: begin
        res.cls = CLS_ENCODER;
      end
      PH_IGNORE: begin
        res.cls = CLS_DROP;
      end
      PH_FTYPE: begin
        nxt.acc  = acc_m;
        nxt.left = left_m;
        if (done_m) begin
          nxt.hdr   = (acc_m == FRAME_HEADERS);
          nxt.acc   = '0;
          nxt.phase = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        nxt.acc  = low6v;
        nxt.left = e_item_q.vleft;
        if (e_item_q.vleft != 3'd0) begin
          nxt.phase = PH_LEN_MORE;
        end else begin
          len_fin = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        nxt.acc  = acc_m;
        nxt.left = left_m;
        len_fin  = done_m;
      end
      PH_PAYLOAD: begin
        nxt.acc = (cur.acc != '0) ? cur.acc - VARINT_W'(1) : cur.acc;
        res.cls = cur.hdr ? CLS_HEADER : CLS_DROP;
        if (nxt.acc == '0) begin
          res.last  = cur.hdr;
          nxt.hdr   = 1'b0;
          nxt.phase = PH_START;
        end
      end
      default: begin
        res.cls   = CLS_DROP;
        nxt       = CTX_RESET;
      end
    endcase

    // frame length complete: payload count or end of an empty frame
    if (len_fin) begin
      nxt.acc = len_sel;
      nxt.hdr = len_hdr;
      if (len_zero) begin
        nxt.phase = PH_START;
        if (len_hdr) begin
          nxt.hdr  = 1'b0;
          res.last = 1'b1;
          res.cls  = CLS_EMPTY;
        end
      end else begin
        nxt.phase = PH_PAYLOAD;
      end
    end
  end

  // context memory, read data registered with write-first bypass
  always_ff @(posedge clk_i) begin
    if (we) begin
      ctx_mem[wr_idx] <= wr_ctx;
    end
    if (pop) begin
      e_ctx_q  <= (we && (wr_idx == rd_idx)) ? wr_ctx : ctx_mem[rd_idx];
      e_item_q <= head_i.item;
      e_idx_q  <= rd_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_cnt_q  <= '0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (init_busy_q) begin
        if (init_cnt_q == IDX_W'(STREAM_SLOTS - 1)) begin
          init_busy_q <= 1'b0;
        end else begin
          init_cnt_q <= init_cnt_q + IDX_W'(1);
        end
      end
      if (pop) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.data;
  assign m_axis_tuser  = {out_res_q.cls, out_res_q.slot};
  assign m_axis_tlast  = out_res_q.last;

endmodule

/* hdl/http3_stream_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// http3_stream_frame_deframer_unit - http/3 stream deframer, one byte per cycle when not stalled
// throughput: one byte per cycle, also on the same slot, while m_axis_tready holds;
//   set by the single read and write port of the slot context memory with write-first bypass
// reset: after rst_ni the context memory is cleared one slot a cycle, with
//   s_axis_tready low until it is done; the apb port works throughout
// ----------------------------------------------------------------------------
module http3_stream_frame_deframer_unit #(
  parameter int STREAM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [5:0]  s_axis_tuser,   // [3:0] stream_slot, [4] unidirectional, [5] restart
  // classified bytes out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [6:0]  m_axis_tuser,   // [3:0] out_slot, [6:4] byte_class
  output logic        m_axis_tlast,   // section_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dfr_pkg::*;

  logic [MAXHDR_W-1:0] max_hdr_q;
  logic                cfg_wr;
  bk_ctrl_t            bk_ctrl;
  q_head_t             q_head;

  // apb: zero wait states, register index taken from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_HDR);
  assign prdata = (paddr[2] == REG_MAX_HDR) ? {8'b0, max_hdr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hdr_q <= MAXHDR_RESET;
    end else if (cfg_wr) begin
      max_hdr_q <= pwdata[MAXHDR_W-1:0];
    end
  end

  // front: varint length decode and a two-entry queue
  dfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .bk_ctrl_i     (bk_ctrl),
    .head_o        (q_head)
  );

  // back: context read, parse step, context write, result register
  dfr_back #(
    .STREAM_SLOTS (STREAM_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .ctrl_o        (bk_ctrl),
    .max_hdr_i     (max_hdr_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // no byte is taken while the context memory is being cleared
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_ctrl.init_busy |-> !s_axis_tready)
    else $error("byte accepted during context clearing");

  // no pop from an empty queue
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_ctrl.pop |-> q_head.valid)
    else $error("queue popped while empty");

  // a section end is only flagged on header bytes or an empty section
  a_last_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser[6:4] == CLS_HEADER) || (m_axis_tuser[6:4] == CLS_EMPTY))
    else $error("section end on a non-header transfer");

  // an empty section report always ends the section
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[6:4] == CLS_EMPTY)) |-> m_axis_tlast)
    else $error("empty section without section end");

endmodule

/* tb/http3_stream_frame_deframer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http3_stream_frame_deframer_unit_test - self-checking bench of the deframer
// drives framed request, encoder and control streams interleaved over all
// slots, with noise and broken frames, and checks every classified byte
// against a per-slot parse model; idle and stall patterns vary per phase
// ----------------------------------------------------------------------------

// per-slot parse model and queue of predicted classified bytes
class deframer_scoreboard;
  dfr_pkg::res_t   predicted_q[$];
  logic [23:0]     max_hdr;
  dfr_pkg::phase_e phase  [dfr_pkg::SLOT_COUNT];
  logic [61:0]     acc    [dfr_pkg::SLOT_COUNT];
  logic [2:0]      left   [dfr_pkg::SLOT_COUNT];
  logic            in_hdr [dfr_pkg::SLOT_COUNT];
  logic [61:0]     remain [dfr_pkg::SLOT_COUNT];
  int unsigned     errors;

  function new();
    int s;
    max_hdr = dfr_pkg::MAXHDR_RESET;
    errors  = 0;
    for (s = 0; s < dfr_pkg::SLOT_COUNT; s++) clear_ctx(s);
  endfunction

  function void clear_ctx(int s);
    phase[s]  = dfr_pkg::PH_START;
    acc[s]    = '0;
    left[s]   = '0;
    in_hdr[s] = 1'b0;
    remain[s] = '0;
  endfunction

  function bit varint_first(int s, logic [7:0] b);
    acc[s]  = {56'd0, b[5:0]};
    left[s] = 3'((1 << b[7:6]) - 1);
    return left[s] == 3'd0;
  endfunction

  function bit varint_next(int s, logic [7:0] b);
    acc[s] = {acc[s][53:0], b};
    if (left[s] != 3'd0) left[s]--;
    return left[s] == 3'd0;
  endfunction

  function void stream_type_done(int s);
    if (acc[s] == dfr_pkg::TYPE_ENCODER) phase[s] = dfr_pkg::PH_ENCODER;
    else phase[s] = dfr_pkg::PH_IGNORE;
    acc[s] = '0;
  endfunction

  function void frame_type_done(int s);
    in_hdr[s] = (acc[s] == dfr_pkg::FRAME_HEADERS);
    acc[s]    = '0;
    phase[s]  = dfr_pkg::PH_LEN_FIRST;
  endfunction

  function dfr_pkg::cls_e length_done(int s, output logic last);
    logic [61:0] len;
    len    = acc[s];
    acc[s] = '0;
    last   = 1'b0;
    if (in_hdr[s] && len > {38'd0, max_hdr}) in_hdr[s] = 1'b0;
    if (len == '0) begin
      phase[s] = dfr_pkg::PH_START;
      if (in_hdr[s]) begin
        in_hdr[s] = 1'b0;
        last      = 1'b1;
        return dfr_pkg::CLS_EMPTY;
      end
      return dfr_pkg::CLS_FRAMING;
    end
    remain[s] = len;
    phase[s]  = dfr_pkg::PH_PAYLOAD;
    return dfr_pkg::CLS_FRAMING;
  endfunction

  function void note_input(logic [3:0] slot, logic uni, logic restart, logic [7:0] b);
    int            s;
    dfr_pkg::cls_e c;
    logic          last;
    dfr_pkg::res_t r;
    s    = slot % dfr_pkg::SLOT_COUNT;
    c    = dfr_pkg::CLS_FRAMING;
    last = 1'b0;
    if (restart) clear_ctx(s);
    case (phase[s])
      dfr_pkg::PH_START: begin
        if (uni) begin
          if (varint_first(s, b)) stream_type_done(s);
          else phase[s] = dfr_pkg::PH_STYPE;
        end else begin
          if (varint_first(s, b)) frame_type_done(s);
          else phase[s] = dfr_pkg::PH_FTYPE;
        end
      end
      dfr_pkg::PH_STYPE:   if (varint_next(s, b)) stream_type_done(s);
      dfr_pkg::PH_ENCODER: c = dfr_pkg::CLS_ENCODER;
      dfr_pkg::PH_IGNORE:  c = dfr_pkg::CLS_DROP;
      dfr_pkg::PH_FTYPE:   if (varint_next(s, b)) frame_type_done(s);
      dfr_pkg::PH_LEN_FIRST: begin
        if (varint_first(s, b)) c = length_done(s, last);
        else phase[s] = dfr_pkg::PH_LEN_MORE;
      end
      dfr_pkg::PH_LEN_MORE: if (varint_next(s, b)) c = length_done(s, last);
      default: begin
        if (remain[s] != '0) remain[s]--;
        if (in_hdr[s]) c = dfr_pkg::CLS_HEADER;
        else c = dfr_pkg::CLS_DROP;
        if (remain[s] == '0) begin
          if (in_hdr[s]) last = 1'b1;
          in_hdr[s] = 1'b0;
          phase[s]  = dfr_pkg::PH_START;
        end
      end
    endcase
    r.slot = slot;
    r.cls  = c;
    r.data = b;
    r.last = last;
    predicted_q.insert(predicted_q.size(), r);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_result(logic [3:0] slot, logic [2:0] cls, logic [7:0] data, logic last);
    dfr_pkg::res_t e;
    if (predicted_q.size() == 0) begin
      report($sformatf("unpredicted result slot %0d byte %02h", slot, data));
      return;
    end
    e = predicted_q[0];
    predicted_q.delete(0);
    if (slot !== e.slot)
      report($sformatf("slot got %0d want %0d (byte %02h)", slot, e.slot, e.data));
    if (cls !== e.cls)
      report($sformatf("class got %0d want %0d (slot %0d byte %02h)", cls, e.cls, e.slot,
                       e.data));
    if (data !== e.data)
      report($sformatf("byte got %02h want %02h (slot %0d)", data, e.data, e.slot));
    if (last !== e.last)
      report($sformatf("section end got %0b want %0b (slot %0d byte %02h)", last, e.last,
                       e.slot, e.data));
  endtask

  function int pending();
    return predicted_q.size();
  endfunction
endclass

module http3_stream_frame_deframer_unit_test;
  import dfr_pkg::*;

  localparam int          STREAM_SLOTS    = 16;
  localparam int          CLK_HALF        = 5;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 206;
  localparam logic [2:0]  MAX_HDR_ADDR    = {REG_MAX_HDR, 2'b00};
  localparam logic [23:0] MAX_HDR_ALL     = 24'hFF_FFFF;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic [5:0]  s_axis_tuser  = '0;   // [3:0] stream_slot, [4] unidirectional, [5] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic [6:0]  m_axis_tuser;         // [3:0] out_slot, [6:4] byte_class
  logic        m_axis_tlast;         // section_last
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  always #CLK_HALF clk_i = ~clk_i;

  http3_stream_frame_deframer_unit #(
    .STREAM_SLOTS (STREAM_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  deframer_scoreboard sb;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic [23:0] cur_max_hdr    = MAXHDR_RESET;

  // stream generator: bytes still to send per slot, and how that stream began
  logic [7:0]  stream_q   [STREAM_SLOTS][$];
  bit          gen_uni    [STREAM_SLOTS];
  bit          gen_fresh  [STREAM_SLOTS];
  bit          gen_broken [STREAM_SLOTS];
  logic [3:0]  last_slot = '0;

  // limit per phase; phase five draws a random small limit instead
  logic [23:0] phase_max [PHASES] = '{MAX_HDR_ALL, 24'd0, 24'd5, MAXHDR_RESET,
                                      24'd1, 24'd0, MAX_HDR_ALL, 24'd12};

  // both handshakes are sampled here with pre-edge values; the watchdog counts
  // cycles in which neither side completes a transfer
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tuser[3:0], s_axis_tuser[4], s_axis_tuser[5], s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[3:0], m_axis_tuser[6:4], m_axis_tdata, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // one byte transfer; valid stays high into the next call when no gap is drawn
  task automatic send_byte(input logic [3:0] slot, input logic uni, input logic restart,
                           input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {restart, uni, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every predicted byte is out, plus the pipeline depth
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= MAX_HDR_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write the limit with junk above bit 23, then read it back
  task automatic set_max_hdr(input logic [23:0] v);
    logic [31:0] rd;
    apb_transfer(1'b1, {8'($urandom), v}, rd);
    apb_transfer(1'b0, 32'($urandom), rd);
    if (rd[23:0] !== v)
      sb.report($sformatf("max header read back %06h want %06h", rd[23:0], v));
    sb.max_hdr  = v;
    cur_max_hdr = v;
  endtask

  function automatic logic [61:0] random_varint_value();
    case ($urandom_range(3))
      0:       return 62'($urandom_range(63));
      1:       return 62'($urandom_range(16383));
      2:       return 62'($urandom & 32'h3FFF_FFFF);
      default: return 62'({$urandom, $urandom});
    endcase
  endfunction

  // mostly the shortest encoding, sometimes a longer one for the same value
  task automatic queue_varint(input int s, input logic [61:0] v);
    int          code;
    int          nbytes;
    int          i;
    logic [63:0] word;
    if (v < 62'd64) code = 0;
    else if (v < 62'd16384) code = 1;
    else if (v < 62'h4000_0000) code = 2;
    else code = 3;
    if ($urandom_range(3) == 0) code = $urandom_range(3, code);
    nbytes = 1 << code;
    word   = (64'(code) << (8 * nbytes - 2)) | 64'(v);
    for (i = nbytes - 1; i >= 0; i--) stream_q[s].insert(stream_q[s].size(), word[8*i +: 8]);
  endtask

  // queue the next piece of a slot: a new stream, or one more request frame
  task automatic refill(input int s);
    logic [61:0] ftype;
    logic [61:0] len;
    int          k;
    int          n;
    if (gen_broken[s] || gen_uni[s] || $urandom_range(7) == 0) begin
      gen_fresh[s]  = 1'b1;
      gen_broken[s] = 1'b0;
      gen_uni[s]    = ($urandom_range(2) == 0);
      if (gen_uni[s]) begin
        if ($urandom_range(99) < 60) queue_varint(s, TYPE_ENCODER);
        else queue_varint(s, random_varint_value());
        n = $urandom_range(16, 1);
        repeat (n) stream_q[s].insert(stream_q[s].size(), 8'($urandom));
        return;
      end
    end
    k = $urandom_range(99);
    if (k < 55) ftype = FRAME_HEADERS;
    else if (k < 75) ftype = '0;
    else ftype = random_varint_value();
    k = $urandom_range(99);
    n = -1;
    if (k < 8) begin
      len = '0;
    end else if (k < 22 && cur_max_hdr <= 24'd40) begin
      // right at the limit or just above it
      len = 62'(cur_max_hdr) + 62'($urandom_range(2));
    end else if (k < 28) begin
      // any length, payload cut short and the stream abandoned
      len           = random_varint_value();
      n             = $urandom_range(6);
      gen_broken[s] = 1'b1;
    end else begin
      len = 62'($urandom_range(20, 1));
    end
    queue_varint(s, ftype);
    queue_varint(s, len);
    if (n < 0) n = int'(len);
    repeat (n) stream_q[s].insert(stream_q[s].size(), 8'($urandom));
  endtask

  // mostly well-formed stream bytes, some noise that breaks the slot's stream
  task automatic random_item();
    logic [3:0] s;
    logic [7:0] b;
    logic       first;
    logic       uni;
    if ($urandom_range(99) < 12) begin
      s = 4'($urandom);
      send_byte(s, 1'($urandom), ($urandom_range(3) == 0), 8'($urandom));
      stream_q[s].delete();
      gen_broken[s] = 1'b1;
      return;
    end
    if ($urandom_range(1) == 0) s = 4'($urandom);
    else s = last_slot;
    if (stream_q[s].size() == 0) refill(s);
    b            = stream_q[s][0];
    stream_q[s].delete(0);
    first        = gen_fresh[s];
    gen_fresh[s] = 1'b0;
    uni          = gen_uni[s];
    // direction flag flipped mid-stream now and then
    if (!first && $urandom_range(9) == 0) uni = ~uni;
    send_byte(s, uni, first, b);
    last_slot = s;
  endtask

  initial begin
    int          p;
    int          s;
    logic [23:0] mh;
    sb = new();
    for (s = 0; s < STREAM_SLOTS; s++) gen_broken[s] = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, limit at its reset value, no idling
    // headers frame of two bytes, the second closes the section
    send_byte(4'd0, 1'b0, 1'b1, 8'h01);
    send_byte(4'd0, 1'b0, 1'b0, 8'h02);
    send_byte(4'd0, 1'b0, 1'b0, 8'hAA);
    send_byte(4'd0, 1'b0, 1'b0, 8'h55);
    // empty header section
    send_byte(4'd1, 1'b0, 1'b1, 8'h01);
    send_byte(4'd1, 1'b0, 1'b0, 8'h00);
    // zero-length data frame, the next byte opens a new frame
    send_byte(4'd2, 1'b0, 1'b1, 8'h00);
    send_byte(4'd2, 1'b0, 1'b0, 8'h00);
    send_byte(4'd2, 1'b0, 1'b0, 8'h00);
    // encoder stream with a two-byte type, flag dropped on the last byte
    send_byte(4'd3, 1'b1, 1'b1, 8'h40);
    send_byte(4'd3, 1'b1, 1'b0, 8'h02);
    send_byte(4'd3, 1'b1, 1'b0, 8'h00);
    send_byte(4'd3, 1'b0, 1'b0, 8'hFF);
    // control stream, everything after the type is dropped
    send_byte(4'd4, 1'b1, 1'b1, 8'h00);
    send_byte(4'd4, 1'b1, 1'b0, 8'h7F);
    // unknown frame type, its payload dropped
    send_byte(4'd5, 1'b0, 1'b1, 8'h40);
    send_byte(4'd5, 1'b0, 1'b0, 8'h21);
    send_byte(4'd5, 1'b0, 1'b0, 8'h01);
    send_byte(4'd5, 1'b0, 1'b0, 8'h12);
    // headers one above the limit become data, then the slot restarts
    send_byte(4'd15, 1'b0, 1'b1, 8'h01);
    send_byte(4'd15, 1'b0, 1'b0, 8'h80);
    send_byte(4'd15, 1'b0, 1'b0, 8'h10);
    send_byte(4'd15, 1'b0, 1'b0, 8'h00);
    send_byte(4'd15, 1'b0, 1'b0, 8'h01);
    send_byte(4'd15, 1'b0, 1'b0, 8'hFF);
    send_byte(4'd15, 1'b0, 1'b1, 8'h01);
    drain();

    // random phases: new limit while idle, then interleaved streams
    for (p = 0; p < PHASES; p++) begin
      mh = phase_max[p];
      if (p == 5) mh = 24'($urandom_range(30));
      set_max_hdr(mh);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/dfr_pkg.sv
hdl/dfr_front.sv
hdl/dfr_back.sv
hdl/http3_stream_frame_deframer_unit.sv
tb/http3_stream_frame_deframer_unit_test.sv
